// File: sv/dibt_pkg.sv
package dibt_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 23;

    localparam logic [CFG_IDX_W-1:0] CFG_FLOW_POS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOW_NEG = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_POS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_NEG = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ART_FRAC = 3'd4;

    localparam logic [22:0] FLOW_POS_RST = 23'd13107;
    localparam logic [22:0] FLOW_NEG_RST = 23'd13107;
    localparam logic [22:0] RATE_POS_RST = 23'd32768;
    localparam logic [22:0] RATE_NEG_RST = 23'd262144;
    localparam logic [16:0] ART_FRAC_RST = 17'd32768;
    localparam logic [16:0] FRAC_ONE     = 17'd65536;

    localparam logic [30:0] Q30_ONE       = 31'h4000_0000;
    localparam logic [4:0]  EXP_TERMS     = 5'd16;
    localparam logic [23:0] EXP_INT_LIMIT = 24'd22;

    localparam int MUL_A_W   = 48;
    localparam int MUL_B_W   = 32;
    localparam int MUL_RES_W = 56;
    localparam int SUM_W     = 57;

    typedef struct packed {
        logic                 start;
        logic [MUL_A_W-1:0]   a;
        logic [MUL_B_W-1:0]   b;
        logic [5:0]           shift;
        logic                 rnd;
    } mul_req_t;

    // floor((2^32 - 1) / k), used as a reciprocal for the series divisions
    function automatic logic [31:0] recip(input logic [4:0] k);
        logic [31:0] r;
        unique case (k)
            5'd1:    r = 32'd4294967295;
            5'd2:    r = 32'd2147483647;
            5'd3:    r = 32'd1431655765;
            5'd4:    r = 32'd1073741823;
            5'd5:    r = 32'd858993459;
            5'd6:    r = 32'd715827882;
            5'd7:    r = 32'd613566756;
            5'd8:    r = 32'd536870911;
            5'd9:    r = 32'd477218588;
            5'd10:   r = 32'd429496729;
            5'd11:   r = 32'd390451572;
            5'd12:   r = 32'd357913941;
            5'd13:   r = 32'd330382099;
            5'd14:   r = 32'd306783378;
            5'd15:   r = 32'd286331153;
            5'd16:   r = 32'd268435455;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

    function automatic logic signed [SUM_W-1:0] apply_sign(input logic neg,
                                                           input logic [MUL_RES_W-1:0] mag);
        logic signed [SUM_W-1:0] v;
        v = signed'({1'b0, mag});
        return neg ? -v : v;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] v);
        logic signed [31:0] r;
        if (v > SUM_W'(signed'(32'sh7FFF_FFFF))) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < SUM_W'(signed'(32'sh8000_0000))) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [47:0] sat48(input logic signed [SUM_W-1:0] v);
        logic signed [47:0] r;
        if (v > SUM_W'(signed'(48'sh7FFF_FFFF_FFFF))) begin
            r = 48'sh7FFF_FFFF_FFFF;
        end else if (v < SUM_W'(signed'(48'sh8000_0000_0000))) begin
            r = 48'sh8000_0000_0000;
        end else begin
            r = v[47:0];
        end
        return r;
    endfunction

endpackage

// File: sv/dibt_mul.sv
module dibt_mul (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  dibt_pkg::mul_req_t        req,
    output logic                      done,
    output logic [dibt_pkg::MUL_RES_W-1:0] result
);
    import dibt_pkg::*;

    localparam int PROD_W = MUL_A_W + MUL_B_W;

    logic [1:0]              phase_reg;
    logic [MUL_A_W-1:0]      a_reg;
    logic [15:0]             bh_reg;
    logic [5:0]              shift_reg;
    logic                    rnd_reg;
    logic [PROD_W-1:0]       acc_reg;
    logic                    done_reg;
    logic [MUL_RES_W-1:0]    result_reg;

    logic [MUL_A_W-1:0]      op_a;
    logic [15:0]             op_b;
    logic [MUL_A_W+15:0]     prod;
    logic [PROD_W-1:0]       rnd_add;
    logic [PROD_W-1:0]       shifted;

    // one 48x16 product per cycle in the start and accumulate phases of a multiply: low half of b first, then high half
    always_comb begin
        op_a    = (phase_reg == 2'd0) ? req.a : a_reg;
        op_b    = (phase_reg == 2'd0) ? req.b[15:0] : bh_reg;
        prod    = op_a * op_b;
        rnd_add = rnd_reg ? (PROD_W'(1) << (shift_reg - 6'd1)) : '0;
        shifted = (acc_reg + rnd_add) >> shift_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= 2'd0;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            unique case (phase_reg)
                2'd0: begin
                    if (req.start) begin
                        a_reg     <= req.a;
                        bh_reg    <= req.b[31:16];
                        shift_reg <= req.shift;
                        rnd_reg   <= req.rnd;
                        acc_reg   <= PROD_W'(prod);
                        phase_reg <= 2'd1;
                    end
                end
                2'd1: begin
                    acc_reg   <= acc_reg + (PROD_W'(prod) << 16);
                    phase_reg <= 2'd2;
                end
                2'd2: begin
                    result_reg <= shifted[MUL_RES_W-1:0];
                    done_reg   <= 1'b1;
                    phase_reg  <= 2'd0;
                end
                default: phase_reg <= 2'd0;
            endcase
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

`ifndef ASSERT_OFF
    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        req.start |-> phase_reg == 2'd0)
        else $error("multiply started while busy");
    a_done_after: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == 2'd2 |=> done_reg)
        else $error("multiply result not flagged");
    a_done_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> phase_reg == 2'd0)
        else $error("done while still busy");
`endif

endmodule

// File: sv/dual_input_biexp_tissue_model_top.sv
// Dual-input bi-exponential tissue model. Each beat on the s_ side is one time
// point (time stamp, arterial and portal venous concentration, first-of-series
// flag in s_tuser); each one yields one saturated tissue concentration beat on
// the m_ side. All multiplies but the quotient check run through one 48x16
// multiplier under a sequencer, which waits for each product before it starts
// the next, and s_tready is low while an item is in work. A first-of-series
// point is done after the plasma mix. Any other point runs a pass per
// compartment, with one multiply for each whole unit of dt*rate; the two exp()
// series of 16 terms dominate. After reset the block computes exp(-1) before it
// first raises s_tready. Configuration writes land at once and are meant for idle times.
module dual_input_biexp_tissue_model_top (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [dibt_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [dibt_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [95:0]                        s_tdata,  // time_stamp, art_conc, ven_conc
    input  logic [0:0]                         s_tuser,  // first_sample
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [31:0]                        m_tdata   // tissue_conc
);
    import dibt_pkg::*;

    typedef enum logic [13:0] {
        ST_IDLE  = 14'b00000000000001,
        ST_MIX_A = 14'b00000000000010,
        ST_MIX_V = 14'b00000000000100,
        ST_RATE  = 14'b00000000001000,
        ST_TERM  = 14'b00000000010000,
        ST_DIV   = 14'b00000000100000,
        ST_FIX   = 14'b00000001000000,
        ST_INT   = 14'b00000010000000,
        ST_PP    = 14'b00000100000000,
        ST_S     = 14'b00001000000000,
        ST_CONV  = 14'b00010000000000,
        ST_FNEG  = 14'b00100000000000,
        ST_FPOS  = 14'b01000000000000,
        ST_OUT   = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;

    logic [22:0] flow_pos_reg, flow_neg_reg, rate_pos_reg, rate_neg_reg;
    logic [16:0] art_frac_reg;

    logic [31:0]        time_reg;
    logic signed [31:0] ca_reg, cv_reg;
    logic               first_reg;
    logic               init_reg;
    logic               wait_reg;

    logic signed [33:0] mix_reg;
    logic signed [31:0] plasma_reg;
    logic [31:0]        prev_time_reg;
    logic signed [31:0] prev_plasma_reg;
    logic signed [47:0] conv_pos_reg, conv_neg_reg;
    logic [31:0]        dt_reg;
    logic               comp_reg;
    logic [4:0]         nint_reg;
    logic [30:0]        f_reg, term_reg, xdiv_reg, q0_reg, e_reg, e1_reg;
    logic signed [32:0] acc_reg;
    logic [4:0]         k_reg;
    logic signed [33:0] s_reg;
    logic signed [48:0] a_reg;
    logic signed [SUM_W-1:0] c_reg;

    logic               m_tvalid_reg;
    logic [31:0]        m_tdata_reg;

    mul_req_t               mul_req;
    logic                   mul_done;
    logic [MUL_RES_W-1:0]   mul_res;
    logic                   mul_neg;
    logic                   mul_state;

    logic [16:0]        fa, fv;
    logic [31:0]        ca_mag, cv_mag, pp_mag;
    logic [32:0]        s_mag;
    logic signed [47:0] conv_sel;
    logic [47:0]        conv_mag;
    logic [22:0]        rate_sel;
    logic signed [SUM_W-1:0] mul_sgn;
    logic signed [SUM_W-1:0] mix_sum;
    logic signed [31:0] p_new;
    logic [39:0]        x_dk;
    logic [31:0]        q_inc;
    logic [36:0]        q_chk;
    logic [30:0]        q_fix;
    logic signed [32:0] acc_new;
    logic [30:0]        e_sat;
    logic signed [SUM_W-1:0] conv_sum;

    always_comb begin
        fa       = (art_frac_reg > FRAC_ONE) ? FRAC_ONE : art_frac_reg;
        fv       = FRAC_ONE - fa;
        ca_mag   = ca_reg[31] ? 32'(-ca_reg) : 32'(ca_reg);
        cv_mag   = cv_reg[31] ? 32'(-cv_reg) : 32'(cv_reg);
        pp_mag   = prev_plasma_reg[31] ? 32'(-prev_plasma_reg) : 32'(prev_plasma_reg);
        s_mag    = s_reg[33] ? 33'(-s_reg) : 33'(s_reg);
        conv_sel = comp_reg ? conv_neg_reg : conv_pos_reg;
        conv_mag = conv_sel[47] ? 48'(-conv_sel) : 48'(conv_sel);
        rate_sel = comp_reg ? rate_neg_reg : rate_pos_reg;

        mul_state = 1'b1;
        mul_neg   = 1'b0;
        mul_req   = '0;
        mul_req.rnd   = 1'b1;
        mul_req.shift = 6'd30;
        unique case (state_reg)
            ST_MIX_A: begin
                mul_req.a = 48'(ca_mag);  mul_req.b = 32'(fa);
                mul_req.shift = 6'd16;    mul_neg = ca_reg[31];
            end
            ST_MIX_V: begin
                mul_req.a = 48'(cv_mag);  mul_req.b = 32'(fv);
                mul_req.shift = 6'd16;    mul_neg = cv_reg[31];
            end
            ST_RATE: begin
                mul_req.a = 48'(dt_reg);  mul_req.b = 32'(rate_sel);
                mul_req.shift = 6'd16;
            end
            ST_TERM: begin
                mul_req.a = 48'(term_reg); mul_req.b = 32'(f_reg);
            end
            ST_DIV: begin
                mul_req.a = 48'(xdiv_reg); mul_req.b = recip(k_reg);
                mul_req.shift = 6'd32;     mul_req.rnd = 1'b0;
            end
            ST_INT: begin
                mul_req.a = 48'(e_reg);   mul_req.b = 32'(e1_reg);
                mul_state = (nint_reg != 5'd0);
            end
            ST_PP: begin
                mul_req.a = 48'(pp_mag);  mul_req.b = 32'(e_reg);
                mul_neg = prev_plasma_reg[31];
            end
            ST_S: begin
                mul_req.a = 48'(s_mag);   mul_req.b = dt_reg;
                mul_req.shift = 6'd17;    mul_neg = s_reg[33];
            end
            ST_CONV: begin
                mul_req.a = conv_mag;     mul_req.b = 32'(e_reg);
                mul_neg = conv_sel[47];
            end
            ST_FNEG: begin
                mul_req.a = (conv_neg_reg[47] ? 48'(-conv_neg_reg) : 48'(conv_neg_reg));
                mul_req.b = 32'(flow_neg_reg);
                mul_req.shift = 6'd16;    mul_neg = conv_neg_reg[47];
            end
            ST_FPOS: begin
                mul_req.a = (conv_pos_reg[47] ? 48'(-conv_pos_reg) : 48'(conv_pos_reg));
                mul_req.b = 32'(flow_pos_reg);
                mul_req.shift = 6'd16;    mul_neg = conv_pos_reg[47];
            end
            ST_IDLE, ST_FIX, ST_OUT: mul_state = 1'b0;
            default: mul_state = 1'b0;
        endcase
        mul_req.start = mul_state && !wait_reg;

        mul_sgn  = apply_sign(mul_neg, mul_res);
        mix_sum  = SUM_W'(mix_reg) + mul_sgn;
        p_new    = sat32(mix_sum);
        x_dk     = mul_res[39:0];
        // correct the reciprocal quotient by at most one
        q_inc    = {1'b0, q0_reg} + 32'd1;
        q_chk    = 37'(q_inc) * 37'(k_reg);
        q_fix    = (q_chk <= 37'(xdiv_reg)) ? q_inc[30:0] : q0_reg;
        acc_new  = k_reg[0] ? acc_reg - 33'(q_fix) : acc_reg + 33'(q_fix);
        if (acc_new < 33'sd0) begin
            e_sat = '0;
        end else if (acc_new > 33'(Q30_ONE)) begin
            e_sat = Q30_ONE;
        end else begin
            e_sat = acc_new[30:0];
        end
        conv_sum = SUM_W'(a_reg) + mul_sgn;
    end

    dibt_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mul_req),
        .done    (mul_done),
        .result  (mul_res)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (s_tvalid) state_next = ST_MIX_A;
            ST_MIX_A: if (mul_done) state_next = ST_MIX_V;
            ST_MIX_V: if (mul_done) state_next = first_reg ? ST_OUT : ST_RATE;
            ST_RATE:  if (mul_done) state_next = (x_dk[39:16] >= EXP_INT_LIMIT) ? ST_PP : ST_TERM;
            ST_TERM:  if (mul_done) state_next = ST_DIV;
            ST_DIV:   if (mul_done) state_next = ST_FIX;
            ST_FIX: begin
                if (k_reg == EXP_TERMS) begin
                    state_next = init_reg ? ST_IDLE : ST_INT;
                end else begin
                    state_next = ST_TERM;
                end
            end
            ST_INT:   if (nint_reg == 5'd0) state_next = ST_PP;
            ST_PP:    if (mul_done) state_next = ST_S;
            ST_S:     if (mul_done) state_next = ST_CONV;
            ST_CONV:  if (mul_done) state_next = comp_reg ? ST_FNEG : ST_RATE;
            ST_FNEG:  if (mul_done) state_next = ST_FPOS;
            ST_FPOS:  if (mul_done) state_next = ST_OUT;
            ST_OUT:   if (!m_tvalid_reg || m_tready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_TERM;
            init_reg        <= 1'b1;
            wait_reg        <= 1'b0;
            m_tvalid_reg    <= 1'b0;
            flow_pos_reg    <= FLOW_POS_RST;
            flow_neg_reg    <= FLOW_NEG_RST;
            rate_pos_reg    <= RATE_POS_RST;
            rate_neg_reg    <= RATE_NEG_RST;
            art_frac_reg    <= ART_FRAC_RST;
            prev_time_reg   <= '0;
            prev_plasma_reg <= '0;
            conv_pos_reg    <= '0;
            conv_neg_reg    <= '0;
            // exp(-1) series runs first
            f_reg           <= Q30_ONE;
            term_reg        <= Q30_ONE;
            acc_reg         <= 33'(Q30_ONE);
            k_reg           <= 5'd1;
        end else begin
            state_reg <= state_next;
            if (mul_req.start) begin
                wait_reg <= 1'b1;
            end else if (mul_done) begin
                wait_reg <= 1'b0;
            end
            // in ST_OUT the output register is reloaded below instead
            if (m_tvalid_reg && m_tready && state_reg != ST_OUT) begin
                m_tvalid_reg <= 1'b0;
            end

            if (cfg_wr_en) begin
                unique case (cfg_index)
                    CFG_FLOW_POS: flow_pos_reg <= cfg_wdata;
                    CFG_FLOW_NEG: flow_neg_reg <= cfg_wdata;
                    CFG_RATE_POS: rate_pos_reg <= cfg_wdata;
                    CFG_RATE_NEG: rate_neg_reg <= cfg_wdata;
                    CFG_ART_FRAC: art_frac_reg <= cfg_wdata[16:0];
                    default: ;
                endcase
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        time_reg  <= s_tdata[31:0];
                        ca_reg    <= s_tdata[63:32];
                        cv_reg    <= s_tdata[95:64];
                        first_reg <= s_tuser[0];
                    end
                end
                ST_MIX_A: if (mul_done) mix_reg <= 34'(mul_sgn);
                ST_MIX_V: begin
                    if (mul_done) begin
                        if (first_reg) begin
                            prev_time_reg   <= time_reg;
                            prev_plasma_reg <= p_new;
                            conv_pos_reg    <= '0;
                            conv_neg_reg    <= '0;
                            c_reg           <= '0;
                        end else begin
                            plasma_reg <= p_new;
                            dt_reg     <= (time_reg >= prev_time_reg) ?
                                          time_reg - prev_time_reg : 32'd0;
                            comp_reg   <= 1'b0;
                        end
                    end
                end
                ST_RATE: begin
                    if (mul_done) begin
                        if (x_dk[39:16] >= EXP_INT_LIMIT) begin
                            e_reg <= '0;
                        end else begin
                            nint_reg <= x_dk[20:16];
                            f_reg    <= {1'b0, x_dk[15:0], 14'b0};
                            term_reg <= Q30_ONE;
                            acc_reg  <= 33'(Q30_ONE);
                            k_reg    <= 5'd1;
                        end
                    end
                end
                ST_TERM: if (mul_done) xdiv_reg <= mul_res[30:0] + 31'(k_reg >> 1);
                ST_DIV:  if (mul_done) q0_reg <= mul_res[30:0];
                ST_FIX: begin
                    term_reg <= q_fix;
                    acc_reg  <= acc_new;
                    k_reg    <= k_reg + 5'd1;
                    if (k_reg == EXP_TERMS) begin
                        if (init_reg) begin
                            e1_reg   <= e_sat;
                            init_reg <= 1'b0;
                        end else begin
                            e_reg <= e_sat;
                        end
                    end
                end
                ST_INT: begin
                    if (mul_done) begin
                        e_reg    <= mul_res[30:0];
                        nint_reg <= nint_reg - 5'd1;
                    end
                end
                ST_PP: if (mul_done) s_reg <= 34'(SUM_W'(plasma_reg) + mul_sgn);
                ST_S:  if (mul_done) a_reg <= 49'(mul_sgn);
                ST_CONV: begin
                    if (mul_done) begin
                        if (comp_reg) begin
                            conv_neg_reg    <= sat48(conv_sum);
                            prev_time_reg   <= time_reg;
                            prev_plasma_reg <= plasma_reg;
                        end else begin
                            conv_pos_reg <= sat48(conv_sum);
                            comp_reg     <= 1'b1;
                        end
                    end
                end
                ST_FNEG: if (mul_done) c_reg <= mul_sgn;
                ST_FPOS: if (mul_done) c_reg <= c_reg + mul_sgn;
                ST_OUT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tdata_reg  <= sat32(c_reg);
                        m_tvalid_reg <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef ASSERT_OFF
    a_done_waited: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_done |-> wait_reg)
        else $error("multiply result with no request outstanding");
    a_accept_start: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> state_reg == ST_MIX_A)
        else $error("accepted beat did not start the sequence");
    a_term_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_FIX |-> k_reg >= 5'd1 && k_reg <= EXP_TERMS)
        else $error("series term index out of range");
`endif

endmodule

// File: verif/dual_input_biexp_tissue_model_top_tb.sv
module dual_input_biexp_tissue_model_top_tb;
    import dibt_pkg::*;

    localparam longint CONV_HI = (64'sd1 <<< 47) - 1;
    localparam longint CONV_LO = -(64'sd1 <<< 47);
    localparam longint C32_HI = 64'sd2147483647;
    localparam longint C32_LO = -64'sd2147483648;
    localparam int Q30_SHIFT = 30;
    localparam int CYCLE_LIMIT = 2000000;

    typedef struct {
        logic [31:0] time_stamp;
        logic [31:0] art_conc;
        logic [31:0] ven_conc;
        logic        first_sample;
    } sample_t;

    // round(a*b / 2^s), ties away from zero handled by callers on magnitudes
    function automatic longint unsigned rnd_mul(longint unsigned a, longint unsigned b, int s);
        longint unsigned hi, lo, m;
        int t;
        hi = a * (b >> 16);
        lo = a * (b & 64'hFFFF);
        m = hi + (lo >> 16);
        if (s <= 16) return m + ((lo & 64'hFFFF) >> 15);
        t = s - 16;
        return (m + (64'd1 << (t - 1))) >> t;
    endfunction

    function automatic longint rnd_smul(longint a, longint unsigned b, int s);
        longint unsigned mag, r;
        mag = (a < 0) ? longint'(-a) : longint'(a);
        r = rnd_mul(mag, b, s);
        return (a < 0) ? -longint'(r) : longint'(r);
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint unsigned decay_frac(longint unsigned f);
        longint acc;
        longint unsigned term;
        acc = 64'sd1 <<< Q30_SHIFT;
        term = 64'd1 << Q30_SHIFT;
        for (int k = 1; k <= 16; k++) begin
            term = rnd_mul(term, f, Q30_SHIFT);
            term = (term + k / 2) / k;
            if (k % 2) acc -= longint'(term);
            else acc += longint'(term);
        end
        return longint'(clip(acc, 0, 64'sd1 <<< Q30_SHIFT));
    endfunction

    function automatic longint unsigned decay(longint unsigned x);
        longint unsigned n, r, e1;
        n = x >> 16;
        if (n >= 22) return 0;
        r = decay_frac((x & 64'hFFFF) << 14);
        e1 = decay_frac(64'd1 << Q30_SHIFT);
        for (longint unsigned i = 0; i < n; i++) r = rnd_mul(r, e1, Q30_SHIFT);
        return r;
    endfunction

    function automatic longint conv_update(longint conv, longint unsigned rate,
                                           longint unsigned dt, longint p, longint pp);
        longint unsigned e;
        longint s, a;
        e = decay(rnd_mul(dt, rate, 16));
        s = p + rnd_smul(pp, e, Q30_SHIFT);
        a = rnd_smul(s, dt, 17);
        return clip(rnd_smul(conv, e, Q30_SHIFT) + a, CONV_LO, CONV_HI);
    endfunction

    class tissue_scoreboard;
        longint unsigned flow_pos, flow_neg, rate_pos, rate_neg, art_frac;
        longint unsigned last_time;
        longint last_plasma, conv_pos, conv_neg;
        logic [31:0] pending_conc[$];
        int errors;

        function new();
            flow_pos = FLOW_POS_RST; flow_neg = FLOW_NEG_RST;
            rate_pos = RATE_POS_RST; rate_neg = RATE_NEG_RST;
            art_frac = ART_FRAC_RST;
            last_time = 0; last_plasma = 0; conv_pos = 0; conv_neg = 0;
            errors = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [22:0] val);
            case (idx)
                CFG_FLOW_POS: flow_pos = val;
                CFG_FLOW_NEG: flow_neg = val;
                CFG_RATE_POS: rate_pos = val;
                CFG_RATE_NEG: rate_neg = val;
                CFG_ART_FRAC: art_frac = val[16:0];
                default: ;
            endcase
        endfunction

        function void note_sample(sample_t s);
            longint unsigned fa, fv, t, dt;
            longint ca, cv, p, c;
            t = s.time_stamp;
            ca = longint'(signed'(s.art_conc));
            cv = longint'(signed'(s.ven_conc));
            fa = art_frac > 65536 ? 65536 : art_frac;
            fv = 65536 - fa;
            p = clip(rnd_smul(ca, fa, 16) + rnd_smul(cv, fv, 16), C32_LO, C32_HI);
            if (s.first_sample) begin
                last_time = t; last_plasma = p; conv_pos = 0; conv_neg = 0;
                pending_conc.push_back(32'd0);
                return;
            end
            dt = t >= last_time ? t - last_time : 0;
            conv_pos = conv_update(conv_pos, rate_pos, dt, p, last_plasma);
            conv_neg = conv_update(conv_neg, rate_neg, dt, p, last_plasma);
            last_time = t; last_plasma = p;
            c = rnd_smul(conv_neg, flow_neg, 16) + rnd_smul(conv_pos, flow_pos, 16);
            c = clip(c, C32_LO, C32_HI);
            pending_conc.push_back(c[31:0]);
        endfunction

        function void check_conc(logic [31:0] got);
            logic [31:0] want;
            if (pending_conc.size() == 0) begin
                $error("tissue_conc: unexpected beat, actual %h", got);
                errors++;
                return;
            end
            want = pending_conc.pop_front();
            if (got !== want) begin
                $error("tissue_conc: expected %h actual %h", want, got);
                errors++;
            end
        endfunction
    endclass

    logic aclk, aresetn;
    logic cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic s_tvalid, s_tready, m_tvalid, m_tready;
    logic [95:0] s_tdata;
    logic [0:0] s_tuser;
    logic [31:0] m_tdata;

    tissue_scoreboard sb;
    int cycles;
    bit long_hold;
    logic [31:0] series_time;

    dual_input_biexp_tissue_model_top uut (.*);

    initial begin
        aclk = 0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("dual_input_biexp_tissue_model_top verification failed");
                $finish;
            end
        end
    end

    // receiver: own stall pattern, plus one long hold-off on request
    initial begin
        int pat;
        m_tready = 0;
        pat = 0;
        forever begin
            @(posedge aclk);
            pat++;
            if (long_hold) m_tready <= 0;
            else if (pat % 64 < 20) m_tready <= 1;
            else m_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_conc(m_tdata);
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [22:0] val);
        cfg_wr_en <= 1; cfg_index <= idx; cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 0;
        // cfg_wr_en drops between writes
        @(posedge aclk);
        sb.set_reg(idx, val);
    endtask

    task automatic send_sample(sample_t s);
        s_tvalid <= 1;
        s_tdata <= {s.ven_conc, s.art_conc, s.time_stamp};
        s_tuser <= s.first_sample;
        do @(posedge aclk); while (!s_tready);
        sb.note_sample(s);
    endtask

    task automatic idle_gap();
        int n;
        n = $urandom_range(0, 3) == 0 ? $urandom_range(1, 20) : 0;
        if (n > 0) begin
            s_tvalid <= 0;
            repeat (n) @(posedge aclk);
        end
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (sb.pending_conc.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_conc();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom_range(0, 32'h0400_0000);
            default: return 32'(signed'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
        endcase
    endfunction

    // random step in time: mostly modest, sometimes large or backwards
    function automatic sample_t next_point(bit first);
        sample_t s;
        case ($urandom_range(0, 9))
            0: series_time = $urandom;
            1: series_time = series_time - $urandom_range(0, 32'h0002_0000);
            2: series_time = series_time + $urandom_range(32'h0010_0000, 32'h0100_0000);
            default: series_time = series_time + $urandom_range(0, 32'h0002_0000);
        endcase
        s.time_stamp = series_time;
        s.art_conc = rand_conc();
        s.ven_conc = rand_conc();
        s.first_sample = first;
        return s;
    endfunction

    function automatic sample_t mk(logic [31:0] t, logic [31:0] a, logic [31:0] v, logic f);
        sample_t s;
        s.time_stamp = t; s.art_conc = a; s.ven_conc = v; s.first_sample = f;
        return s;
    endfunction

    initial begin
        int sent, burst;
        logic [22:0] r23;
        sb = new();
        long_hold = 0;
        aresetn = 0; cfg_wr_en = 0; cfg_index = '0; cfg_wdata = '0;
        s_tvalid = 0; s_tdata = '0; s_tuser = '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: continue from zero state, extremes, decreasing time
        send_sample(mk(32'h0001_0000, 32'h0001_0000, 32'h0002_0000, 0));
        send_sample(mk(32'h0000_8000, 32'h7FFF_FFFF, 32'h8000_0000, 1));
        send_sample(mk(32'h0001_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0));
        send_sample(mk(32'h0000_4000, 32'h8000_0000, 32'h8000_0000, 0));
        send_sample(mk(32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0));
        send_sample(mk(32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 1));
        send_sample(mk(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 0));
        send_sample(mk(32'h0016_0000, 32'h0010_0000, 32'h0020_0000, 0));
        drain();

        write_reg(CFG_FLOW_POS, 23'd6553600);
        write_reg(CFG_FLOW_NEG, 23'd6553600);
        write_reg(CFG_RATE_POS, 23'd0);
        write_reg(CFG_RATE_NEG, 23'd6553600);
        write_reg(CFG_ART_FRAC, 23'h1FFFF);  // above one, saturates
        write_reg(3'd7, 23'h7FFFFF);         // out of range, ignored
        send_sample(mk(32'h0001_0000, 32'h0100_0000, 32'h7FFF_FFFF, 1));
        send_sample(mk(32'h0003_0000, 32'h7FFF_FFFF, 32'h0000_0000, 0));
        send_sample(mk(32'h0100_0000, 32'h7FFF_FFFF, 32'h0000_0000, 0));
        send_sample(mk(32'h0100_8000, 32'h8000_0000, 32'h0000_0000, 0));
        drain();
        write_reg(CFG_ART_FRAC, 23'd0);
        write_reg(CFG_FLOW_POS, 23'd0);
        write_reg(CFG_FLOW_NEG, 23'h7FFFFF);
        send_sample(mk(32'h0000_0000, 32'h0000_0000, 32'h8000_0000, 1));
        send_sample(mk(32'h0000_1000, 32'h0000_0000, 32'h8000_0000, 0));
        drain();

        sent = 0;
        series_time = 0;
        for (int phase = 0; phase < 5; phase++) begin
            if (phase > 0) begin
                r23 = $urandom_range(0, 6553600); write_reg(CFG_FLOW_POS, r23);
                r23 = $urandom_range(0, 6553600); write_reg(CFG_FLOW_NEG, r23);
                r23 = $urandom_range(0, 327680); write_reg(CFG_RATE_POS, r23);
                r23 = phase == 4 ? 23'h7FFFFF : $urandom_range(0, 327680);
                write_reg(CFG_RATE_NEG, r23);
                r23 = $urandom_range(0, 65536); write_reg(CFG_ART_FRAC, r23);
            end
            if (phase == 2) begin
                fork
                    begin
                        long_hold = 1;
                        repeat (3000) @(posedge aclk);
                        long_hold = 0;
                    end
                join_none
            end
            while (sent < (phase + 1) * 100) begin
                burst = $urandom_range(1, 12);
                for (int i = 0; i < burst; i++) begin
                    send_sample(next_point($urandom_range(0, 15) == 0));
                    sent++;
                end
                idle_gap();
            end
            drain();
        end

        while (long_hold) @(posedge aclk);
        drain();
        if (sb.errors == 0 && sb.pending_conc.size() == 0)
            $display("dual_input_biexp_tissue_model_top verification clean");
        else
            $display("dual_input_biexp_tissue_model_top verification failed");
        $finish;
    end
endmodule

// File: dual_input_biexp_tissue_model_top.f
sv/dibt_pkg.sv
sv/dibt_mul.sv
sv/dual_input_biexp_tissue_model_top.sv
verif/dual_input_biexp_tissue_model_top_tb.sv
